/* rtl/fdbed_pkg.sv */
`default_nettype none
package fdbed_pkg;
    localparam int SectorSlots = 32;
    localparam logic [12:0] AdrHdrTrk = 13'h0018;
    localparam logic [12:0] AdrHdrSec = 13'h0019;
    localparam logic [12:0] AdrHdrChk = 13'h001A;
    localparam logic [12:0] AdrHdrId1 = 13'h0017;
    localparam logic [12:0] AdrHdrId2 = 13'h0016;
    localparam logic [12:0] AdrStatus = 13'h0020;
    localparam logic [12:0] AdrTarget = 13'h0022;
    localparam logic [12:0] AdrProtect = 13'h001E;
    localparam logic [28:0] RpmNumer = 29'd375000000;
    localparam logic [13:0] TicksPerRev = 14'd12500;
    localparam logic [15:0] RpmMin = 16'd28000;
    localparam logic [15:0] RpmMax = 16'd32000;
    localparam logic [15:0] MinInterval = 16'd10000;
    // interval bounds where the rounded revolution count steps up
    localparam logic [15:0] RevEdge1 = 16'(int'(TicksPerRev) * 3 / 2);
    localparam logic [15:0] RevEdge2 = 16'(int'(TicksPerRev) * 5 / 2);
    localparam logic [15:0] RevEdge3 = 16'(int'(TicksPerRev) * 7 / 2);
    localparam logic [15:0] RevEdge4 = 16'(int'(TicksPerRev) * 9 / 2);

    typedef enum logic [2:0] {
        EV_NONE = 3'd0, EV_MOTOR = 3'd1, EV_PHASE = 3'd2, EV_TARGET = 3'd3,
        EV_PROTECT = 3'd4, EV_DENSITY = 3'd5, EV_HEADER = 3'd6, EV_RPM = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_DIV, ST_CHECK, ST_EMIT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [34:0] numer;
        logic [15:0] denom;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [34:0] quot;
    } t_div_rsp;
endpackage
`default_nettype wire

/* rtl/fdbed_if.sv */
`default_nettype none
interface fdbed_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] bus_snapshot;
    logic [15:0] time_ticks;
    modport source (output valid, bus_snapshot, time_ticks, input ready);
    modport sink (input valid, bus_snapshot, time_ticks, output ready);
endinterface

interface fdbed_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [27:0] event_payload;
    logic        last_of_run;
    logic [7:0]  head_half_track;
    logic        position_known;
    logic        head_stepping;
    logic [7:0]  target_track_out;
    logic        target_known;
    modport source (output valid, event_kind, event_payload, last_of_run, head_half_track,
        position_known, head_stepping, target_track_out, target_known, input ready);
    modport sink (input valid, event_kind, event_payload, last_of_run, head_half_track,
        position_known, head_stepping, target_track_out, target_known, output ready);
endinterface
`default_nettype wire

/* rtl/fdbed_div.sv */
`default_nettype none
module fdbed_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  fdbed_pkg::t_div_req i_req,
    output fdbed_pkg::t_div_rsp o_rsp
);
    // restoring divide, one quotient bit per cycle
    logic [34:0] r_quot, n_quot;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [16:0] w_sh;

    always_comb begin
        n_quot = r_quot;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh = {r_rem, r_quot[34]};
        if (i_req.start) begin
            n_quot = i_req.numer;
            n_rem = '0;
            n_den = i_req.denom;
            n_cnt = 6'd35;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = 16'(w_sh - {1'b0, r_den});
                n_quot = {r_quot[33:0], 1'b1};
            end else begin
                n_rem = w_sh[15:0];
                n_quot = {r_quot[33:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule
`default_nettype wire

/* rtl/floppy_drive_bus_event_decoder_core.sv */
// flow: an input beat is captured, decoded and checked, then emitted as a run;
//   a repeated sector runs the rpm divide and is checked again before the emit
// throughput: one input beat per run of 1 to 3 result beats, a beat per ready cycle
// input ready again in the cycle after the last result beat of the run
// reset: synchronous active low, clears control state and the sector seen bits
`default_nettype none
module floppy_drive_bus_event_decoder_core (
    input wire i_clk,
    input wire i_rst_n,
    fdbed_in_if.sink    i_in,
    fdbed_out_if.source o_out
);
    fdbed_pkg::t_state r_state, n_state;
    logic [31:0] r_snap;
    logic [15:0] r_now;

    logic r_motor_seen, r_motor_level, r_phase_seen, r_density_seen, r_protect_seen;
    logic r_protect_level, r_target_valid, r_anchor_valid, r_seek_busy;
    logic [1:0] r_phase_value, r_density_value;
    logic [7:0] r_target_track, r_half_track_pos, r_header_track, r_header_sector;
    logic [2:0] r_header_stage;
    logic [15:0] r_header_time;
    logic [fdbed_pkg::SectorSlots-1:0] r_seen;
    logic [15:0] r_sec_time [fdbed_pkg::SectorSlots];

    logic [2:0]  r_kind [3];
    logic [27:0] r_pay [3];
    logic [1:0]  r_n, r_idx;
    logic        r_div_phase;
    logic [15:0] r_dt;
    logic [2:0]  r_revs;
    logic [15:0] r_sec_rd;
    logic        r_rpm_go;

    fdbed_pkg::t_div_req w_req;
    fdbed_pkg::t_div_rsp w_rsp;

    fdbed_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic [7:0]  w_d;
    logic [12:0] w_adr;
    logic        w_port, w_ram;

    always_comb begin
        w_d = {r_snap[4], r_snap[3], r_snap[2], r_snap[1], r_snap[0],
               r_snap[5], r_snap[6], r_snap[7]};
        for (int i = 0; i < 11; i++) w_adr[i] = r_snap[23 - i];
        w_adr[11] = r_snap[11];
        w_adr[12] = r_snap[12];
        w_port = !r_snap[25];
        w_ram = r_snap[25];
    end

    assign i_in.ready = (r_state == fdbed_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdbed_pkg::ST_IDLE: if (i_in.valid) n_state = fdbed_pkg::ST_DECODE;
            fdbed_pkg::ST_DECODE: n_state = fdbed_pkg::ST_CHECK;
            fdbed_pkg::ST_DIV: if (w_rsp.done) n_state = fdbed_pkg::ST_CHECK;
            fdbed_pkg::ST_CHECK: n_state = (!r_div_phase && r_rpm_go) ? fdbed_pkg::ST_DIV
                                                                       : fdbed_pkg::ST_EMIT;
            fdbed_pkg::ST_EMIT:
                if (o_out.ready && r_idx == r_n - 2'd1) n_state = fdbed_pkg::ST_IDLE;
            default: n_state = fdbed_pkg::ST_IDLE;
        endcase
    end

    // rpm*100 = (numer * revs + dt / 2) / dt
    always_comb begin
        w_req.start = 1'b0;
        w_req.numer = '0;
        w_req.denom = 16'd1;
        if (r_state == fdbed_pkg::ST_CHECK && !r_div_phase && r_rpm_go) begin
            w_req.start = 1'b1;
            w_req.numer = 35'(fdbed_pkg::RpmNumer) * 35'(r_revs) + 35'(r_dt[15:1]);
            w_req.denom = r_dt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdbed_pkg::ST_IDLE;
            r_motor_seen <= 1'b0; r_motor_level <= 1'b0;
            r_phase_seen <= 1'b0; r_phase_value <= 2'd0;
            r_density_seen <= 1'b0; r_density_value <= 2'd2;
            r_protect_seen <= 1'b0; r_protect_level <= 1'b0;
            r_target_valid <= 1'b0; r_target_track <= 8'd0;
            r_anchor_valid <= 1'b0; r_half_track_pos <= 8'd0;
            r_seek_busy <= 1'b0; r_header_stage <= 3'd0;
            r_header_track <= 8'd0; r_header_sector <= 8'd0;
            r_header_time <= 16'd0; r_seen <= '0;
            r_rpm_go <= 1'b0; r_n <= 2'd0; r_idx <= 2'd0; r_div_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                fdbed_pkg::ST_IDLE: begin
                    if (i_in.valid) begin
                        r_snap <= i_in.bus_snapshot;
                        r_now <= i_in.time_ticks;
                        r_idx <= 2'd0;
                        r_div_phase <= 1'b0;
                        r_rpm_go <= 1'b0;
                    end
                end
                fdbed_pkg::ST_DECODE: begin : dec
                    logic [2:0] n;
                    logic mot;
                    logic [1:0] ph, den, delta;
                    logic clr;
                    logic [7:0] pos;
                    logic anc;
                    logic [15:0] dt;
                    logic [8:0] p2;
                    logic go;
                    logic [2:0] rv;
                    n = 3'd0; clr = 1'b0; go = 1'b0;
                    mot = w_d[2]; ph = w_d[1:0]; den = w_d[6:5];
                    delta = ph - r_phase_value;
                    pos = r_half_track_pos; anc = r_anchor_valid;
                    dt = 16'd0;
                    if (w_port && w_adr[3:0] == 4'd0) begin
                        if (!r_motor_seen || mot != r_motor_level) begin
                            r_motor_seen <= 1'b1;
                            r_motor_level <= mot;
                            r_kind[n[1:0]] <= fdbed_pkg::EV_MOTOR;
                            r_pay[n[1:0]] <= 28'(mot);
                            n = n + 3'd1;
                            if (r_motor_seen && !mot) clr = 1'b1;
                        end
                        if (!r_phase_seen) begin
                            r_phase_seen <= 1'b1;
                            r_phase_value <= ph;
                        end else if (ph != r_phase_value) begin
                            clr = 1'b1;
                            r_phase_value <= ph;
                            r_kind[n[1:0]] <= fdbed_pkg::EV_PHASE;
                            r_pay[n[1:0]] <= 28'({mot, delta, ph, r_phase_value});
                            n = n + 3'd1;
                            if (anc) begin
                                if (delta == 2'd1) begin
                                    if (pos < 8'd254) pos = pos + 8'd1;
                                end else if (delta == 2'd3) begin
                                    pos = (pos > 8'd2) ? pos - 8'd1 : 8'd2;
                                end
                            end
                        end
                        if (!r_density_seen || den != r_density_value) begin
                            r_density_seen <= 1'b1;
                            r_density_value <= den;
                            r_kind[n[1:0]] <= fdbed_pkg::EV_DENSITY;
                            r_pay[n[1:0]] <= 28'(den);
                            n = n + 3'd1;
                        end
                    end
                    if (clr) r_seen <= '0;
                    if (w_ram && w_adr == fdbed_pkg::AdrHdrTrk) begin
                        r_header_track <= w_d;
                        r_header_stage <= 3'd1;
                    end else if (w_ram && w_adr == fdbed_pkg::AdrHdrSec) begin
                        if (r_header_stage == 3'd1) begin
                            r_header_sector <= w_d;
                            r_header_time <= r_now;
                            r_header_stage <= 3'd2;
                        end else r_header_stage <= 3'd0;
                    end else if (w_ram && w_adr == fdbed_pkg::AdrHdrChk) begin
                        r_header_stage <= (r_header_stage == 3'd2) ? 3'd3 : 3'd0;
                    end else if (w_ram && w_adr == fdbed_pkg::AdrHdrId1) begin
                        r_header_stage <= (r_header_stage == 3'd3) ? 3'd4 : 3'd0;
                    end else if (w_ram && w_adr == fdbed_pkg::AdrHdrId2) begin
                        if (r_header_stage == 3'd4 && r_header_track >= 8'd1 &&
                            r_header_track <= 8'd127 && r_header_sector < 8'd32) begin
                            r_kind[n[1:0]] <= fdbed_pkg::EV_HEADER;
                            r_pay[n[1:0]] <= {r_header_track[6:0], r_header_sector[4:0],
                                              r_header_time};
                            n = n + 3'd1;
                            dt = r_header_time - r_sec_rd;
                            // round the interval to whole revolutions
                            if (dt < fdbed_pkg::RevEdge1) rv = 3'd1;
                            else if (dt < fdbed_pkg::RevEdge2) rv = 3'd2;
                            else if (dt < fdbed_pkg::RevEdge3) rv = 3'd3;
                            else rv = 3'd4;
                            r_dt <= dt;
                            r_revs <= rv;
                            if (r_seen[r_header_sector[4:0]] && dt >= fdbed_pkg::MinInterval &&
                                dt < fdbed_pkg::RevEdge4)
                                go = 1'b1;
                            r_seen[r_header_sector[4:0]] <= 1'b1;
                            r_sec_time[r_header_sector[4:0]] <= r_header_time;
                        end
                        r_header_stage <= 3'd0;
                    end
                    if (w_ram && w_adr == fdbed_pkg::AdrStatus) begin
                        r_seek_busy <= w_d[6];
                        if (r_seek_busy && !w_d[6] && r_target_valid &&
                            r_target_track >= 8'd1 && r_target_track <= 8'd127) begin
                            p2 = {r_target_track, 1'b0};
                            pos = (p2 > 9'd254) ? 8'd254 : p2[7:0];
                            anc = 1'b1;
                        end
                    end
                    if (w_ram && w_adr == fdbed_pkg::AdrTarget) begin
                        r_target_track <= w_d;
                        r_target_valid <= 1'b1;
                        r_kind[n[1:0]] <= fdbed_pkg::EV_TARGET;
                        r_pay[n[1:0]] <= 28'(w_d);
                        n = n + 3'd1;
                        if (w_d == 8'd1) begin
                            pos = 8'd2; anc = 1'b1;
                        end else if (!anc && !r_seek_busy && w_d >= 8'd1 &&
                                     w_d <= 8'd127) begin
                            p2 = {w_d, 1'b0};
                            pos = (p2 > 9'd254) ? 8'd254 : p2[7:0];
                            anc = 1'b1;
                        end
                    end
                    if (w_ram && w_adr == fdbed_pkg::AdrProtect) begin
                        if (!r_protect_seen || w_d[4] != r_protect_level) begin
                            r_protect_seen <= 1'b1;
                            r_protect_level <= w_d[4];
                            r_kind[n[1:0]] <= fdbed_pkg::EV_PROTECT;
                            r_pay[n[1:0]] <= 28'(w_d[4]);
                            n = n + 3'd1;
                        end
                    end
                    if (n == 3'd0) begin
                        r_kind[0] <= fdbed_pkg::EV_NONE;
                        r_pay[0] <= '0;
                        n = 3'd1;
                    end
                    r_n <= n[1:0];
                    r_rpm_go <= go;
                    r_half_track_pos <= pos;
                    r_anchor_valid <= anc;
                end
                fdbed_pkg::ST_DIV: ;
                fdbed_pkg::ST_CHECK: begin
                    r_div_phase <= 1'b1;
                    if (r_div_phase && r_rpm_go && w_rsp.quot >= 35'(fdbed_pkg::RpmMin) &&
                        w_rsp.quot <= 35'(fdbed_pkg::RpmMax)) begin
                        r_kind[r_n] <= fdbed_pkg::EV_RPM;
                        r_pay[r_n] <= {r_pay[r_n - 2'd1][27:21], 2'b00, r_revs,
                                       w_rsp.quot[15:0]};
                        r_n <= r_n + 2'd1;
                    end
                end
                fdbed_pkg::ST_EMIT: if (o_out.ready) r_idx <= r_idx + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sec_rd <= r_sec_time[r_header_sector[4:0]];
    end

    assign o_out.valid = (r_state == fdbed_pkg::ST_EMIT);
    assign o_out.event_kind = r_kind[r_idx];
    assign o_out.event_payload = r_pay[r_idx];
    assign o_out.last_of_run = (r_idx == r_n - 2'd1);
    assign o_out.head_half_track = r_half_track_pos;
    assign o_out.position_known = r_anchor_valid;
    assign o_out.head_stepping = r_seek_busy;
    assign o_out.target_track_out = r_target_track;
    assign o_out.target_known = r_target_valid;
endmodule
`default_nettype wire

/* rtl/fdbed_checker.sv */
`default_nettype none
module fdbed_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire [2:0] i_kind,
    input wire i_last
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input ready during output");
    a_one_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready) else $error("second accept");
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == fdbed_pkg::EV_NONE) |-> i_last)
        else $error("none not last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid) else $error("output dropped");
endmodule

bind floppy_drive_bus_event_decoder_core fdbed_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_kind(o_out.event_kind), .i_last(o_out.last_of_run)
);
`default_nettype wire

/* tb/floppy_drive_bus_event_decoder_core_tb.sv */
`timescale 1ns / 1ps
`default_nettype none

class event_scoreboard;
    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] payload;
        logic        last;
        logic [7:0]  half_track;
        logic        pos_known;
        logic        stepping;
        logic [7:0]  target;
        logic        tgt_known;
    } t_result;

    t_result pending[$];
    int      errors;

    bit       motor_seen, motor_level, phase_seen, density_seen, protect_seen, protect_level;
    bit [1:0] phase_value, density_value;
    bit       target_valid, anchor_valid, seek_busy;
    bit [7:0] target_track, half_track_pos, header_track, header_sector;
    bit [2:0] header_stage;
    bit [15:0] header_time;
    bit        sector_seen[32];
    bit [15:0] sector_time[32];

    function new();
        errors = 0;
        motor_seen = 0; motor_level = 0; phase_seen = 0; phase_value = 2'd0;
        density_seen = 0; density_value = 2'd2; protect_seen = 0; protect_level = 0;
        target_valid = 0; target_track = 8'd0; anchor_valid = 0; half_track_pos = 8'd0;
        seek_busy = 0; header_stage = 3'd0; header_track = 8'd0; header_sector = 8'd0;
        header_time = 16'd0;
        foreach (sector_seen[i]) begin
            sector_seen[i] = 0;
            sector_time[i] = 16'd0;
        end
    endfunction

    function void clear_sectors();
        foreach (sector_seen[i]) sector_seen[i] = 0;
    endfunction

    function bit [7:0] anchor_of(bit [7:0] trk);
        return (trk > 8'd127) ? 8'd254 : {trk[6:0], 1'b0};
    endfunction

    function void note_beat(bit [31:0] snap, bit [15:0] now);
        bit [2:0]  kinds[$];
        bit [27:0] pays[$];
        bit        port;
        bit [12:0] adr;
        bit [7:0]  d;
        bit        mot, wp, was;
        bit [1:0]  ph, den, old, delta;
        bit [7:0]  sec;
        bit [27:0] trk;
        int        dt, revs;
        longint    rpm;
        t_result   r;
        port = !snap[25];
        d = {snap[4], snap[3], snap[2], snap[1], snap[0], snap[5], snap[6], snap[7]};
        for (int i = 0; i < 11; i++) adr[i] = snap[23 - i];
        adr[11] = snap[11];
        adr[12] = snap[12];
        if (port && adr[3:0] == 4'd0) begin
            mot = d[2];
            ph = d[1:0];
            den = d[6:5];
            if (!motor_seen) begin
                motor_seen = 1; motor_level = mot;
                kinds.push_back(fdbed_pkg::EV_MOTOR); pays.push_back(28'(mot));
            end else if (mot != motor_level) begin
                motor_level = mot;
                kinds.push_back(fdbed_pkg::EV_MOTOR); pays.push_back(28'(mot));
                if (!mot) clear_sectors();
            end
            if (!phase_seen) begin
                phase_seen = 1; phase_value = ph;
            end else if (ph != phase_value) begin
                old = phase_value;
                delta = ph - old;
                clear_sectors();
                phase_value = ph;
                kinds.push_back(fdbed_pkg::EV_PHASE);
                pays.push_back({21'd0, mot, delta, ph, old});
                if (anchor_valid) begin
                    if (delta == 2'd1) begin
                        if (half_track_pos < 8'd254) half_track_pos = half_track_pos + 8'd1;
                    end else if (delta == 2'd3) begin
                        half_track_pos = (half_track_pos > 8'd2) ? half_track_pos - 8'd1
                                                                 : 8'd2;
                    end
                end
            end
            if (!density_seen || den != density_value) begin
                density_seen = 1; density_value = den;
                kinds.push_back(fdbed_pkg::EV_DENSITY); pays.push_back(28'(den));
            end
        end
        if (!port) begin
            case (adr)
                fdbed_pkg::AdrHdrTrk: begin
                    header_track = d; header_stage = 3'd1;
                end
                fdbed_pkg::AdrHdrSec: begin
                    if (header_stage == 3'd1) begin
                        header_sector = d; header_time = now; header_stage = 3'd2;
                    end else header_stage = 3'd0;
                end
                fdbed_pkg::AdrHdrChk: header_stage = (header_stage == 3'd2) ? 3'd3 : 3'd0;
                fdbed_pkg::AdrHdrId1: header_stage = (header_stage == 3'd3) ? 3'd4 : 3'd0;
                fdbed_pkg::AdrHdrId2: begin
                    if (header_stage == 3'd4 && header_track >= 8'd1 &&
                            header_track <= 8'd127 && header_sector < 8'd32) begin
                        sec = header_sector;
                        trk = {header_track[6:0], 21'd0};
                        kinds.push_back(fdbed_pkg::EV_HEADER);
                        pays.push_back(trk | {7'd0, sec[4:0], header_time});
                        if (sector_seen[sec]) begin
                            dt = int'(16'(header_time - sector_time[sec]));
                            if (dt >= 10000) begin
                                revs = (dt + 6250) / 12500;
                                if (revs >= 1 && revs <= 4) begin
                                    rpm = (64'd375000000 * revs + dt / 2) / dt;
                                    if (rpm >= 28000 && rpm <= 32000) begin
                                        kinds.push_back(fdbed_pkg::EV_RPM);
                                        pays.push_back(trk | {7'd0, 5'(revs), 16'(rpm)});
                                    end
                                end
                            end
                        end
                        sector_seen[sec] = 1;
                        sector_time[sec] = header_time;
                    end
                    header_stage = 3'd0;
                end
                fdbed_pkg::AdrStatus: begin
                    was = seek_busy;
                    seek_busy = d[6];
                    if (was && !seek_busy && target_valid && target_track >= 8'd1 &&
                            target_track <= 8'd127) begin
                        half_track_pos = anchor_of(target_track);
                        anchor_valid = 1;
                    end
                end
                fdbed_pkg::AdrTarget: begin
                    target_track = d; target_valid = 1;
                    kinds.push_back(fdbed_pkg::EV_TARGET); pays.push_back(28'(d));
                    if (d == 8'd1) begin
                        half_track_pos = 8'd2; anchor_valid = 1;
                    end else if (!anchor_valid && !seek_busy && d >= 8'd1 && d <= 8'd127) begin
                        half_track_pos = anchor_of(d); anchor_valid = 1;
                    end
                end
                fdbed_pkg::AdrProtect: begin
                    wp = d[4];
                    if (!protect_seen || wp != protect_level) begin
                        protect_seen = 1; protect_level = wp;
                        kinds.push_back(fdbed_pkg::EV_PROTECT); pays.push_back(28'(wp));
                    end
                end
                default: ;
            endcase
        end
        if (kinds.size() == 0) begin
            kinds.push_back(fdbed_pkg::EV_NONE); pays.push_back(28'd0);
        end
        foreach (kinds[k]) begin
            r.kind = kinds[k]; r.payload = pays[k]; r.last = (k == kinds.size() - 1);
            r.half_track = half_track_pos; r.pos_known = anchor_valid;
            r.stepping = seek_busy; r.target = target_track; r.tgt_known = target_valid;
            pending.push_back(r);
        end
    endfunction

    function void check_beat(t_result got);
        t_result e;
        if (pending.size() == 0) begin
            $error("unexpected result beat kind %0d", got.kind);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.kind !== e.kind) begin
            $error("event_kind exp %0d got %0d", e.kind, got.kind); errors++;
        end
        if (got.payload !== e.payload) begin
            $error("event_payload exp %h got %h", e.payload, got.payload); errors++;
        end
        if (got.last !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, got.last); errors++;
        end
        if (got.half_track !== e.half_track) begin
            $error("head_half_track exp %0d got %0d", e.half_track, got.half_track); errors++;
        end
        if (got.pos_known !== e.pos_known) begin
            $error("position_known exp %0d got %0d", e.pos_known, got.pos_known); errors++;
        end
        if (got.stepping !== e.stepping) begin
            $error("head_stepping exp %0d got %0d", e.stepping, got.stepping); errors++;
        end
        if (got.target !== e.target) begin
            $error("target_track_out exp %0d got %0d", e.target, got.target); errors++;
        end
        if (got.tgt_known !== e.tgt_known) begin
            $error("target_known exp %0d got %0d", e.tgt_known, got.tgt_known); errors++;
        end
    endfunction
endclass

module testbench;
    logic i_clk = 0;
    logic i_rst_n = 0;
    fdbed_in_if  in_ch();
    fdbed_out_if out_ch();

    floppy_drive_bus_event_decoder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    event_scoreboard board = new();
    bit              sink_on;
    bit [1:0]        phase_now;
    bit [15:0]       clock_ticks;
    int              stall_left;

    initial begin
        in_ch.valid = 0;
        in_ch.bus_snapshot = 0;
        in_ch.time_ticks = 0;
        out_ch.ready = 0;
        stall_left = 0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // scramble a data byte and a 13-bit address onto the pins
    function automatic bit [31:0] pack_pins(bit is_port, bit [12:0] adr, bit [7:0] d,
                                             bit [31:0] noise);
        bit [31:0] v;
        v = noise;
        {v[4], v[3], v[2], v[1], v[0], v[5], v[6], v[7]} = d;
        for (int i = 0; i < 11; i++) v[23 - i] = adr[i];
        v[11] = adr[11];
        v[12] = adr[12];
        v[25] = !is_port;
        return v;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(bit [31:0] snap, bit [15:0] ticks);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.bus_snapshot <= snap;
        in_ch.time_ticks <= ticks;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_beat(snap, ticks);
        @(negedge i_clk);
    endtask

    task automatic idle_input();
        in_ch.valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic send_ram(bit [12:0] adr, bit [7:0] d, bit [15:0] ticks);
        send_beat(pack_pins(0, adr, d, $urandom()), ticks);
    endtask

    task automatic send_port(bit [7:0] d);
        bit [12:0] adr;
        adr = 13'($urandom());
        adr[3:0] = 4'd0;
        send_beat(pack_pins(1, adr, d, $urandom()), 16'($urandom()));
    endtask

    task automatic send_header(bit [7:0] trk, bit [7:0] sec, bit [15:0] ticks);
        send_ram(fdbed_pkg::AdrHdrTrk, trk, 16'($urandom()));
        send_ram(fdbed_pkg::AdrHdrSec, sec, ticks);
        send_ram(fdbed_pkg::AdrHdrChk, 8'($urandom()), 16'($urandom()));
        send_ram(fdbed_pkg::AdrHdrId1, 8'($urandom()), 16'($urandom()));
        send_ram(fdbed_pkg::AdrHdrId2, 8'($urandom()), 16'($urandom()));
    endtask

    function automatic bit [7:0] port_byte(bit [1:0] ph, bit mot);
        bit [7:0] d;
        d = 8'($urandom());
        d[1:0] = ph;
        d[2] = mot;
        if ($urandom_range(0, 3) != 0) d[6:5] = board.density_value;
        return d;
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 0;
        end else if (!sink_on) out_ch.ready <= 0;
        else if ($urandom_range(0, 99) < 8) out_ch.ready <= 0;
        else if ($urandom_range(0, 99) < 3) begin
            stall_left <= $urandom_range(10, 40);
            out_ch.ready <= 0;
        end
        else out_ch.ready <= ($urandom_range(0, 99) < 70) || board.pending.size() > 20;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_beat({out_ch.event_kind, out_ch.event_payload, out_ch.last_of_run,
                out_ch.head_half_track, out_ch.position_known, out_ch.head_stepping,
                out_ch.target_track_out, out_ch.target_known});
    end

    initial begin
        #4000000;
        $display("floppy_drive_bus_event_decoder_core test failed");
        $finish;
    end

    initial begin
        int sent, r, wait_cycles;
        bit [7:0] sec;
        bit paused;
        sink_on = 1;
        paused = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed
        send_ram(fdbed_pkg::AdrHdrId2, 8'h00, 16'h0000);
        send_port(8'b0000_0100);
        send_port(8'b0110_0101);
        send_ram(fdbed_pkg::AdrTarget, 8'd1, 16'd0);
        send_port(8'b0110_0100);
        send_port(8'b0110_0111);
        send_port(8'b0110_0110);
        send_port(8'b0110_0010);
        send_ram(fdbed_pkg::AdrStatus, 8'h40, 16'd0);
        send_ram(fdbed_pkg::AdrTarget, 8'd200, 16'd0);
        send_ram(fdbed_pkg::AdrStatus, 8'h00, 16'd0);
        send_ram(fdbed_pkg::AdrStatus, 8'hFF, 16'd0);
        send_ram(fdbed_pkg::AdrTarget, 8'd127, 16'd0);
        send_ram(fdbed_pkg::AdrStatus, 8'hBF, 16'd0);
        send_ram(fdbed_pkg::AdrProtect, 8'h10, 16'd0);
        send_ram(fdbed_pkg::AdrProtect, 8'hEF, 16'd0);
        send_beat(32'hFFFF_FFFF, 16'hFFFF);
        send_beat(32'h0000_0000, 16'h0000);
        send_header(8'd17, 8'd31, 16'd1000);
        send_header(8'd17, 8'd31, 16'd13500);
        send_header(8'd0, 8'd3, 16'd5);
        send_header(8'd128, 8'd3, 16'd5);
        send_header(8'd5, 8'd32, 16'd5);
        send_ram(fdbed_pkg::AdrHdrSec, 8'd4, 16'd0);

        // random
        sent = 0;
        phase_now = board.phase_value;
        clock_ticks = 16'($urandom());
        while (sent < 480) begin
            r = $urandom_range(0, 99);
            if (!paused && sent >= 240) begin
                paused = 1;
                idle_input();
                while (board.pending.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            if (r < 45) begin
                sec = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 15) == 0) sec = 8'($urandom_range(0, 255));
                clock_ticks = clock_ticks + (($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                    16'($urandom_range(1, 4) * 12500 + $urandom_range(0, 400) - 200));
                send_header($urandom_range(0, 7) == 0 ? 8'($urandom()) :
                    8'($urandom_range(1, 127)), sec, clock_ticks);
                sent += 5;
            end else if (r < 55) begin
                send_ram(13'(fdbed_pkg::AdrHdrTrk + $urandom_range(0, 4) - 2),
                    8'($urandom()), 16'($urandom()));
                sent++;
            end else if (r < 70) begin
                if ($urandom_range(0, 5) != 0)
                    phase_now = phase_now + (($urandom_range(0, 1) != 0) ? 2'd1 : 2'd3);
                else phase_now = 2'($urandom());
                send_port(port_byte(phase_now, $urandom_range(0, 9) != 0));
                sent++;
            end else if (r < 78) begin
                send_ram(fdbed_pkg::AdrStatus, 8'($urandom()), 16'd0);
                sent++;
            end else if (r < 86) begin
                send_ram(fdbed_pkg::AdrTarget, $urandom_range(0, 3) == 0 ? 8'($urandom()) :
                    8'($urandom_range(0, 3)), 16'd0);
                sent++;
            end else if (r < 91) begin
                send_ram(fdbed_pkg::AdrProtect, 8'($urandom()), 16'd0);
                sent++;
            end else begin
                send_beat($urandom(), 16'($urandom()));
                sent++;
            end
        end
        idle_input();

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("floppy_drive_bus_event_decoder_core test passed");
        else
            $display("floppy_drive_bus_event_decoder_core test failed");
        $finish;
    end
endmodule
